// ----- hw/rtl/fatsn_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fatsn_pkg;

    localparam int BASE_LEN = 8;
    localparam int EXT_LEN  = 3;

    typedef logic [7:0] t_byte;
    typedef logic [BASE_LEN-1:0][7:0] t_base;
    typedef logic [EXT_LEN-1:0][7:0] t_ext;

    localparam t_byte SPACE_BYTE = 8'h20;
    localparam t_byte DOT_BYTE   = 8'h2E;
    localparam t_byte LOWER_A    = 8'h61;
    localparam t_byte LOWER_Z    = 8'h7A;
    localparam t_byte CASE_GAP   = 8'h20;
    localparam t_byte NUL_BYTE   = 8'h00;

    localparam t_base BASE_SPACES = {BASE_LEN{SPACE_BYTE}};

    function automatic t_byte upcase(input t_byte b);
        if (b >= LOWER_A && b <= LOWER_Z) begin
            return t_byte'(b - CASE_GAP);
        end
        return b;
    endfunction

    function automatic t_byte sum_step(input t_byte sum, input t_byte b);
        return t_byte'({sum[0], sum[7:1]} + b);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/fatsn_parse.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fatsn_parse import fatsn_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_take,
    input  t_byte i_byte,
    input  wire   i_last,
    output t_base o_base,
    output t_ext  o_ext
);

    logic       r_lead,  n_lead;
    logic       r_closed, n_closed;
    logic [3:0] r_bcnt,  n_bcnt;
    t_base      r_base,  n_base;
    logic       r_dot,   n_dot;
    logic [1:0] r_ecnt,  n_ecnt;
    t_ext       r_ext,   n_ext;
    logic       r_ended, n_ended;

    always_comb begin
        n_lead   = r_lead;
        n_closed = r_closed;
        n_bcnt   = r_bcnt;
        n_base   = r_base;
        n_dot    = r_dot;
        n_ecnt   = r_ecnt;
        n_ext    = r_ext;
        n_ended  = r_ended;
        if (!r_ended) begin
            if (i_byte == NUL_BYTE) begin
                n_ended = 1'b1;
            end else if (!(r_lead && i_byte == SPACE_BYTE)) begin
                n_lead = 1'b0;
                if (!r_closed && r_bcnt < 4'(BASE_LEN)) begin
                    if (i_byte == DOT_BYTE) begin
                        n_closed = 1'b1;
                    end else if (i_byte != SPACE_BYTE) begin
                        n_base[3'(3'd7 - r_bcnt[2:0])] = upcase(i_byte);
                        n_bcnt = 4'(r_bcnt + 4'd1);
                    end
                end
                if (i_byte == DOT_BYTE) begin
                    n_dot  = 1'b1;
                    n_ecnt = 2'd0;
                    n_ext  = '0;
                end else if (r_dot && r_ecnt < 2'(EXT_LEN)) begin
                    n_ext[2'(2'd2 - r_ecnt)] = upcase(i_byte);
                    n_ecnt = 2'(r_ecnt + 2'd1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_lead   <= 1'b1;
            r_closed <= 1'b0;
            r_bcnt   <= '0;
            r_base   <= BASE_SPACES;
            r_dot    <= 1'b0;
            r_ecnt   <= '0;
            r_ext    <= '0;
            r_ended  <= 1'b0;
        end else if (i_take) begin
            r_lead   <= n_lead;
            r_closed <= n_closed;
            r_bcnt   <= n_bcnt;
            r_base   <= n_base;
            r_dot    <= n_dot;
            r_ecnt   <= n_ecnt;
            r_ext    <= n_ext;
            r_ended  <= n_ended;
        end
    end

    assign o_base = n_base;
    assign o_ext  = n_ext;

endmodule

`default_nettype wire

// ----- hw/rtl/fat_short_name_and_checksum_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Builds the FAT 8.3 short name of a long file name that arrives one byte per
// transfer, and its long-name entry checksum. One byte is taken in every clock
// cycle unless o_ready is low, as the output is held and the pipeline is full;
// the transfer flagged as last produces one result, which passes through the
// three-register pipeline that forms the checksum, whose first register is
// loaded by the edge that takes that byte, before it reaches the output. The name
// state is cleared by the last byte, so the next name may follow at once.
module fat_short_name_and_checksum_top import fatsn_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_ready,
    input  wire  [7:0]   i_name_byte,
    input  wire          i_is_last,
    output logic         o_valid,
    input  wire          i_ready,
    output logic [63:0]  o_base_name,
    output logic [23:0]  o_ext_name,
    output logic [7:0]   o_name_checksum
);

    logic  in_acc;
    t_base p_base;
    t_ext  p_ext;

    logic  r_v1, r_v2;
    t_base r_b1, r_b2;
    t_ext  r_e1, r_e2;
    t_byte r_sum2, n_sum2, n_sum_out;
    logic  s1_rdy, s2_rdy, out_rdy;

    assign out_rdy = !o_valid || i_ready;
    assign s2_rdy  = !r_v2 || out_rdy;
    assign s1_rdy  = !r_v1 || s2_rdy;
    assign o_ready = s1_rdy;
    assign in_acc  = i_valid && o_ready;

    fatsn_parse u_parse (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (in_acc),
        .i_byte (i_name_byte),
        .i_last (i_is_last),
        .o_base (p_base),
        .o_ext  (p_ext)
    );

    always_comb begin
        n_sum2 = '0;
        for (int k = 0; k < BASE_LEN; k++) begin
            n_sum2 = sum_step(n_sum2, r_b1[BASE_LEN-1-k]);
        end
    end

    always_comb begin
        n_sum_out = r_sum2;
        for (int k = 0; k < EXT_LEN; k++) begin
            n_sum_out = sum_step(n_sum_out, r_e2[EXT_LEN-1-k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_v1 <= in_acc && i_is_last;
            end
            if (s2_rdy) begin
                r_v2 <= r_v1;
            end
            if (out_rdy) begin
                o_valid <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy && in_acc && i_is_last) begin
            r_b1 <= p_base;
            r_e1 <= p_ext;
        end
        if (s2_rdy && r_v1) begin
            r_b2   <= r_b1;
            r_e2   <= r_e1;
            r_sum2 <= n_sum2;
        end
        if (out_rdy && r_v2) begin
            o_base_name     <= r_b2;
            o_ext_name      <= r_e2;
            o_name_checksum <= n_sum_out;
        end
    end

    a_last_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_is_last |=> r_v1)
        else $error("final byte did not load the checksum pipeline");

    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !out_rdy |=> r_v2 && $stable(r_sum2))
        else $error("partial checksum lost while stalled");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_v1 && r_v2 && o_valid)
        else $error("input stalled while the pipeline has room");

endmodule

`default_nettype wire

// ----- verif/fatsn_result_checker.sv -----
`timescale 1ns / 1ps

module fatsn_result_checker import fatsn_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    input  wire         i_ready_in,
    input  wire  [7:0]  i_name_byte,
    input  wire         i_is_last,
    input  wire         i_out_valid,
    input  wire         i_ready,
    input  wire  [63:0] i_base_name,
    input  wire  [23:0] i_ext_name,
    input  wire  [7:0]  i_name_checksum,
    output int          o_fail_count,
    output int          o_names_in_flight
);

    typedef struct packed {
        t_base base;
        t_ext  ext;
        t_byte sum;
    } t_short_name;

    t_short_name short_names_due[$];

    logic  in_leading;
    logic  base_closed;
    int    base_count;
    t_base base_bytes;
    logic  dot_seen;
    int    ext_count;
    t_ext  ext_bytes;
    logic  name_ended;
    int    fault_tally = 0;

    assign o_fail_count = fault_tally;

    function automatic t_byte to_upper_ascii(input t_byte b);
        return (b >= LOWER_A && b <= LOWER_Z) ? t_byte'(b - CASE_GAP) : b;
    endfunction

    function automatic t_byte short_name_sum(input t_base b, input t_ext e);
        t_byte acc;
        acc = '0;
        for (int k = BASE_LEN - 1; k >= 0; k--) begin
            acc = ((acc >> 1) | (acc << 7)) + b[k];
        end
        for (int k = EXT_LEN - 1; k >= 0; k--) begin
            acc = ((acc >> 1) | (acc << 7)) + e[k];
        end
        return acc;
    endfunction

    function automatic void clear_name_state();
        in_leading  = 1'b1;
        base_closed = 1'b0;
        base_count  = 0;
        base_bytes  = BASE_SPACES;
        dot_seen    = 1'b0;
        ext_count   = 0;
        ext_bytes   = '0;
        name_ended  = 1'b0;
    endfunction

    function automatic void absorb_name_byte(input t_byte b);
        if (name_ended) begin
            return;
        end
        if (b == NUL_BYTE) begin
            name_ended = 1'b1;
            return;
        end
        if (in_leading) begin
            if (b == SPACE_BYTE) begin
                return;
            end
            in_leading = 1'b0;
        end
        if (!base_closed && base_count < BASE_LEN) begin
            if (b == DOT_BYTE) begin
                base_closed = 1'b1;
            end else if (b != SPACE_BYTE) begin
                base_bytes[BASE_LEN - 1 - base_count] = to_upper_ascii(b);
                base_count++;
            end
        end
        if (b == DOT_BYTE) begin
            dot_seen  = 1'b1;
            ext_count = 0;
            ext_bytes = '0;
        end else if (dot_seen && ext_count < EXT_LEN) begin
            ext_bytes[EXT_LEN - 1 - ext_count] = to_upper_ascii(b);
            ext_count++;
        end
    endfunction

    task automatic flag_fault(input string what, input logic [63:0] want,
                              input logic [63:0] got);
        fault_tally++;
        if (fault_tally <= 10) begin
            $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_short_name due;
        if (!i_rst_n) begin
            clear_name_state();
            short_names_due.delete();
        end else begin
            // Results are checked before this edge's input transfer is taken in.
            if (i_out_valid && i_ready) begin
                if (short_names_due.size() == 0) begin
                    flag_fault("result with none due", '0, i_base_name);
                end else begin
                    due = short_names_due.pop_front();
                    if (i_base_name !== due.base) begin
                        flag_fault("base name", due.base, i_base_name);
                    end
                    if (i_ext_name !== due.ext) begin
                        flag_fault("extension", 64'(due.ext), 64'(i_ext_name));
                    end
                    if (i_name_checksum !== due.sum) begin
                        flag_fault("checksum", 64'(due.sum), 64'(i_name_checksum));
                    end
                end
            end
            if (i_valid && i_ready_in) begin
                absorb_name_byte(i_name_byte);
                if (i_is_last) begin
                    due.base = base_bytes;
                    due.ext  = ext_bytes;
                    due.sum  = short_name_sum(base_bytes, ext_bytes);
                    short_names_due.push_back(due);
                    clear_name_state();
                end
            end
        end
        o_names_in_flight <= short_names_due.size();
    end

endmodule

// ----- verif/fat_short_name_and_checksum_top_test.sv -----
`timescale 1ns / 1ps

module fat_short_name_and_checksum_top_test import fatsn_pkg::*;;

    localparam int RANDOM_BYTES = 1550;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_name_byte;
    logic        i_is_last;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_base_name;
    logic [23:0] o_ext_name;
    logic [7:0]  o_name_checksum;

    int    fail_count;
    int    names_in_flight;
    int    cycles = 0;
    int    send_mode = 0;
    t_byte name_q[$];

    fat_short_name_and_checksum_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_name_byte     (i_name_byte),
        .i_is_last       (i_is_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_base_name     (o_base_name),
        .o_ext_name      (o_ext_name),
        .o_name_checksum (o_name_checksum)
    );

    fatsn_result_checker i_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .i_ready_in        (o_ready),
        .i_name_byte       (i_name_byte),
        .i_is_last         (i_is_last),
        .i_out_valid       (o_valid),
        .i_ready           (i_ready),
        .i_base_name       (o_base_name),
        .i_ext_name        (o_ext_name),
        .i_name_checksum   (o_name_checksum),
        .o_fail_count      (fail_count),
        .o_names_in_flight (names_in_flight)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_wait(input int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 2);
            default: return $urandom_range(0, 16);
        endcase
    endfunction

    function automatic t_byte pick_name_char();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4) begin
            return t_byte'(LOWER_A + $urandom_range(0, 25));
        end else if (roll < 6) begin
            return t_byte'(8'h41 + $urandom_range(0, 25));
        end else if (roll == 6) begin
            return t_byte'(8'h30 + $urandom_range(0, 9));
        end else if (roll == 7) begin
            return SPACE_BYTE;
        end
        return t_byte'($urandom_range(8'h21, 8'h7E));
    endfunction

    task automatic load_text(input string s);
        name_q.delete();
        for (int i = 0; i < s.len(); i++) begin
            name_q.push_back(t_byte'(s[i]));
        end
    endtask

    // Mostly well-formed names with random content; the rest is raw noise.
    task automatic build_random_name();
        int lead;
        int dots;
        name_q.delete();
        if ($urandom_range(0, 9) < 7) begin
            lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            repeat (lead) name_q.push_back(SPACE_BYTE);
            repeat ($urandom_range(0, 11)) name_q.push_back(pick_name_char());
            dots = ($urandom_range(0, 4) == 0) ? 2 : (($urandom_range(0, 3) == 0) ? 0 : 1);
            repeat (dots) begin
                name_q.push_back(DOT_BYTE);
                repeat ($urandom_range(0, 5)) name_q.push_back(pick_name_char());
            end
            if ($urandom_range(0, 15) == 0) begin
                name_q.push_back(NUL_BYTE);
                repeat ($urandom_range(0, 3)) name_q.push_back(pick_name_char());
            end
            if (name_q.size() == 0) begin
                name_q.push_back(pick_name_char());
            end
        end else begin
            repeat ($urandom_range(1, 16)) name_q.push_back(t_byte'($urandom_range(0, 255)));
        end
    endtask

    task automatic offer_byte(input t_byte b, input logic last);
        int gap;
        gap = draw_wait(send_mode);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_name_byte <= b;
        i_is_last   <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic offer_name(inout int sent);
        send_mode = $urandom_range(0, 2);
        for (int i = 0; i < name_q.size(); i++) begin
            offer_byte(name_q[i], i == name_q.size() - 1);
            sent++;
        end
    endtask

    initial begin
        int sent;
        sent        = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_name_byte = '0;
        i_is_last   = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Leading space, letter-range boundaries and a spaced extension.
        load_text(" z`.{ a");
        offer_name(sent);
        // Base and extension both overlong.
        load_text("abcdefghi.lmnq");
        offer_name(sent);
        // Top byte value, a later dot, then a zero byte ending the name early.
        name_q.delete();
        name_q.push_back(8'hFF);
        name_q.push_back(DOT_BYTE);
        name_q.push_back(t_byte'("b"));
        name_q.push_back(DOT_BYTE);
        name_q.push_back(NUL_BYTE);
        name_q.push_back(t_byte'("x"));
        offer_name(sent);

        sent = 0;
        while (sent < RANDOM_BYTES) begin
            build_random_name();
            offer_name(sent);
        end
        i_valid <= 1'b0;

        while (names_in_flight != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS fat_short_name_and_checksum_top");
        end else begin
            $display("FAIL fat_short_name_and_checksum_top");
        end
        $finish;
    end

    // The receiver draws a random stall per result and once holds off long enough to back up the block.
    initial begin
        int stall;
        int taken;
        int mode;
        taken   = 0;
        mode    = 2;
        i_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(negedge i_clk);
            if (taken % 20 == 0) begin
                mode = $urandom_range(0, 2);
            end
            stall = (taken == HOLD_AT) ? HOLD_CYCLES : draw_wait(mode);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            taken++;
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL fat_short_name_and_checksum_top");
        $finish;
    end

endmodule
